// File: rtl/tfl_pkg.sv
// Shared types, codes and defaults for the ticket free list allocator.
`timescale 1ns / 1ps

package tfl_pkg;

	localparam int DEF_SLOTS       = 256;
	localparam int DEF_HANDLE_BITS = 32;

	localparam int OPCODE_W = 2;
	localparam int TICKET_W = 8;
	localparam int HANDLE_W = 32;

	localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_LOOKUP  = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic clear_wr;
		logic accept;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
	} dp_status_t;

endpackage

// File: rtl/tfl_ctrl.sv
// Controller state machine: clearing pass, accept, execute and result hand-off.
`timescale 1ns / 1ps

module tfl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  tfl_pkg::dp_status_t status_i,
	output tfl_pkg::dp_cmd_t    cmd
);

	tfl_pkg::state_t state_q;
	tfl_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tfl_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tfl_pkg::ST_CLEAR: begin
				if (status_i.clear_last) begin
					state_d = tfl_pkg::ST_IDLE;
				end
			end
			tfl_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = tfl_pkg::ST_EXEC;
				end
			end
			tfl_pkg::ST_EXEC: begin
				if (out_free) begin
					state_d = tfl_pkg::ST_IDLE;
				end
			end
			default: state_d = tfl_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd.clear_wr = 1'b0;
		cmd.accept   = 1'b0;
		cmd.commit   = 1'b0;
		unique case (state_q)
			tfl_pkg::ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
			end
			tfl_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			tfl_pkg::ST_EXEC: begin
				cmd.commit = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// File: rtl/tfl_datapath.sv
// Datapath: free list head, link and handle memories, result register.
`timescale 1ns / 1ps

module tfl_datapath #(
	parameter int SLOTS       = tfl_pkg::DEF_SLOTS,
	parameter int HANDLE_BITS = tfl_pkg::DEF_HANDLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tfl_pkg::dp_cmd_t              cmd,
	output tfl_pkg::dp_status_t           status_o,
	input  logic [tfl_pkg::OPCODE_W-1:0]  opcode,
	input  logic [tfl_pkg::TICKET_W-1:0]  ticket_in,
	input  logic [tfl_pkg::HANDLE_W-1:0]  handle_in,
	output logic [tfl_pkg::TICKET_W-1:0]  ticket_out,
	output logic [tfl_pkg::HANDLE_W-1:0]  handle_out,
	output logic                          status
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW = $clog2(SLOTS + 1);
	localparam logic [31:0] SLOTS_W = 32'(SLOTS);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	logic [LW-1:0]          link_mem [SLOTS];
	logic [HANDLE_BITS-1:0] hdl_mem  [SLOTS];

	logic [LW-1:0]          head_q;
	logic [LW-1:0]          head_d;
	logic [IW-1:0]          cnt_q;
	logic [LW-1:0]          link_rd_q;
	logic [HANDLE_BITS-1:0] hdl_rd_q;

	logic [tfl_pkg::OPCODE_W-1:0] op_s1;
	logic [tfl_pkg::TICKET_W-1:0] tk_s1;
	logic [HANDLE_BITS-1:0]       hd_s1;

	logic [tfl_pkg::TICKET_W-1:0] ticket_q;
	logic [tfl_pkg::HANDLE_W-1:0] handle_q;
	logic                         status_q;

	logic [IW-1:0]          rd_addr;
	logic [IW-1:0]          wr_addr;
	logic                   link_we;
	logic                   hdl_we;
	logic [LW-1:0]          link_wd;
	logic [HANDLE_BITS-1:0] hdl_wd;
	logic                   head_we;

	logic [tfl_pkg::TICKET_W-1:0] t_res;
	logic [tfl_pkg::HANDLE_W-1:0] h_res;
	logic                         st_res;

	logic [31:0] tk_ext;
	logic [31:0] head_ext;
	logic [31:0] cnt_inc;
	logic        tk_ok;
	logic        head_null;

	function automatic logic [tfl_pkg::HANDLE_W-1:0] tfl_handle_out(
		input logic [HANDLE_BITS-1:0] h
	);
		logic [63:0] w;
		w = 64'(h);
		return w[tfl_pkg::HANDLE_W-1:0];
	endfunction

	assign status_o.clear_last = (cnt_q == LAST_IDX);

	assign tk_ext    = 32'(tk_s1);
	assign head_ext  = 32'(head_q);
	assign cnt_inc   = 32'(cnt_q) + 32'd1;
	assign tk_ok     = tk_ext < SLOTS_W;
	assign head_null = head_ext >= SLOTS_W;

	always_comb begin
		logic [31:0] tin;
		tin = 32'(ticket_in);
		if (opcode == tfl_pkg::OP_ALLOC) begin
			rd_addr = head_q[IW-1:0];
		end else begin
			rd_addr = tin[IW-1:0];
		end
	end

	always_comb begin
		wr_addr = tk_ext[IW-1:0];
		link_we = 1'b0;
		hdl_we  = 1'b0;
		link_wd = head_q;
		hdl_wd  = '0;
		head_we = 1'b0;
		head_d  = head_q;
		t_res   = tk_s1;
		h_res   = '0;
		st_res  = 1'b0;
		unique case (op_s1)
			tfl_pkg::OP_ALLOC: begin
				if (head_null) begin
					t_res  = '0;
					st_res = 1'b1;
				end else begin
					wr_addr = head_q[IW-1:0];
					hdl_we  = 1'b1;
					hdl_wd  = hd_s1;
					head_we = 1'b1;
					head_d  = link_rd_q;
					t_res   = head_ext[tfl_pkg::TICKET_W-1:0];
				end
			end
			tfl_pkg::OP_RELEASE: begin
				if (tk_ok) begin
					link_we = 1'b1;
					hdl_we  = 1'b1;
					head_we = 1'b1;
					head_d  = tk_ext[LW-1:0];
				end
			end
			tfl_pkg::OP_LOOKUP: begin
				if (tk_ok) begin
					h_res = tfl_handle_out(hdl_rd_q);
				end
			end
			default: begin
				t_res = tk_s1;
			end
		endcase
		if (!cmd.commit) begin
			link_we = 1'b0;
			hdl_we  = 1'b0;
			head_we = 1'b0;
		end
		if (cmd.clear_wr) begin
			wr_addr = cnt_q;
			link_we = 1'b1;
			hdl_we  = 1'b1;
			link_wd = cnt_inc[LW-1:0];
			hdl_wd  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (head_we) begin
				head_q <= head_d;
			end
			if (cmd.clear_wr && !status_o.clear_last) begin
				cnt_q <= cnt_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [63:0] hin;
		hin = 64'(handle_in);
		if (cmd.accept) begin
			op_s1     <= opcode;
			tk_s1     <= ticket_in;
			hd_s1     <= hin[HANDLE_BITS-1:0];
			link_rd_q <= link_mem[rd_addr];
			hdl_rd_q  <= hdl_mem[rd_addr];
		end
		if (link_we) begin
			link_mem[wr_addr] <= link_wd;
		end
		if (hdl_we) begin
			hdl_mem[wr_addr] <= hdl_wd;
		end
		if (cmd.commit) begin
			ticket_q <= t_res;
			handle_q <= h_res;
			status_q <= st_res;
		end
	end

	assign ticket_out = ticket_q;
	assign handle_out = handle_q;
	assign status     = status_q;

endmodule

// File: rtl/ticket_free_list_allocator.sv
// Top level of the ticket free list allocator: controller plus datapath.
`timescale 1ns / 1ps
//
// channel  handshake            words
// in       in_valid / in_ready  opcode, ticket_in, handle_in
// out      out_valid / out_ready ticket_out, handle_out, status
//
// Each word first reads the link and handle memories at the head slot or
// ticket, then updates them and loads the result register.
// After reset a clearing pass over all SLOTS slots rebuilds the free list; no word
// is taken during it. A result waiting in the output register does not block
// the next word from being taken; only its update cycle waits for the slot.
module ticket_free_list_allocator #(
	parameter int SLOTS       = tfl_pkg::DEF_SLOTS,
	parameter int HANDLE_BITS = tfl_pkg::DEF_HANDLE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [tfl_pkg::OPCODE_W-1:0] opcode,
	input  logic [tfl_pkg::TICKET_W-1:0] ticket_in,
	input  logic [tfl_pkg::HANDLE_W-1:0] handle_in,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tfl_pkg::TICKET_W-1:0] ticket_out,
	output logic [tfl_pkg::HANDLE_W-1:0] handle_out,
	output logic                         status
);

	tfl_pkg::dp_cmd_t    cmd;
	tfl_pkg::dp_status_t dp_status;

	tfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status_i  (dp_status),
		.cmd       (cmd)
	);

	tfl_datapath #(
		.SLOTS       (SLOTS),
		.HANDLE_BITS (HANDLE_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status_o   (dp_status),
		.opcode     (opcode),
		.ticket_in  (ticket_in),
		.handle_in  (handle_in),
		.ticket_out (ticket_out),
		.handle_out (handle_out),
		.status     (status)
	);

endmodule

// File: verif/tfl_checker.sv
// Checker for the ticket free list allocator: predicts every reply word and compares it.
`timescale 1ns / 1ps

module tfl_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [tfl_pkg::OPCODE_W-1:0] opcode,
	input  logic [tfl_pkg::TICKET_W-1:0] ticket_in,
	input  logic [tfl_pkg::HANDLE_W-1:0] handle_in,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [tfl_pkg::TICKET_W-1:0] ticket_out,
	input  logic [tfl_pkg::HANDLE_W-1:0] handle_out,
	input  logic                         status,
	output int                           errors,
	output int                           pending
);

	localparam int SLOTS  = tfl_pkg::DEF_SLOTS;
	localparam int LINK_W = $clog2(SLOTS) + 1;

	typedef struct packed {
		logic [tfl_pkg::TICKET_W-1:0] ticket;
		logic [tfl_pkg::HANDLE_W-1:0] handle;
		logic                         status;
	} reply_t;

	logic [LINK_W-1:0]            head_slot;
	logic [LINK_W-1:0]            link_of   [SLOTS];
	logic [tfl_pkg::HANDLE_W-1:0] handle_of [SLOTS];
	reply_t                       due_replies [$];

	task automatic clear_table();
		for (int i = 0; i < SLOTS; i++) begin
			link_of[i]   = LINK_W'(i + 1);
			handle_of[i] = '0;
		end
		head_slot = '0;
	endtask

	function automatic reply_t run_ticket_op(logic [tfl_pkg::OPCODE_W-1:0] op,
			logic [tfl_pkg::TICKET_W-1:0] tk, logic [tfl_pkg::HANDLE_W-1:0] hd);
		reply_t r;
		int     s;
		r.ticket = tk;
		r.handle = '0;
		r.status = 1'b0;
		case (op)
			tfl_pkg::OP_ALLOC: begin
				if (head_slot >= LINK_W'(SLOTS)) begin
					r.ticket = '0;
					r.status = 1'b1;
				end else begin
					s            = int'(head_slot);
					handle_of[s] = hd;
					head_slot    = link_of[s];
					r.ticket     = tfl_pkg::TICKET_W'(s);
				end
			end
			tfl_pkg::OP_RELEASE: begin
				if (int'(tk) < SLOTS) begin
					link_of[tk]   = head_slot;
					head_slot     = LINK_W'(tk);
					handle_of[tk] = '0;
				end
			end
			tfl_pkg::OP_LOOKUP: begin
				if (int'(tk) < SLOTS)
					r.handle = handle_of[tk];
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("tfl_checker: %s got %0h want %0h at %0t", what, got, want, $time);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			clear_table();
			due_replies.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_replies.size() == 0) begin
					report("reply word with none due, ticket_out", 32'(ticket_out), '0);
				end else begin
					want = due_replies.pop_front();
					if (ticket_out !== want.ticket)
						report("ticket_out", 32'(ticket_out), 32'(want.ticket));
					if (handle_out !== want.handle)
						report("handle_out", handle_out, want.handle);
					if (status !== want.status)
						report("status", 32'(status), 32'(want.status));
				end
			end
			if (in_valid && in_ready)
				due_replies.push_back(run_ticket_op(opcode, ticket_in, handle_in));
			pending = due_replies.size();
		end
	end

endmodule

// File: verif/tb_ticket_free_list_allocator.sv
// Testbench top for the ticket free list allocator: stimulus, handshakes and verdict.
`timescale 1ns / 1ps

module tb_ticket_free_list_allocator;

	localparam logic [tfl_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 1300;

	typedef enum {
		RND_FILL,
		RND_DRAIN,
		RND_MIX,
		RND_NOISE
	} round_kind_t;

	logic                         clk        = 1'b0;
	logic                         arst_n     = 1'b0;
	logic                         in_valid   = 1'b0;
	logic                         in_ready;
	logic [tfl_pkg::OPCODE_W-1:0] opcode     = tfl_pkg::OP_LOOKUP;
	logic [tfl_pkg::TICKET_W-1:0] ticket_in  = '0;
	logic [tfl_pkg::HANDLE_W-1:0] handle_in  = '0;
	logic                         out_valid;
	logic                         out_ready  = 1'b0;
	logic [tfl_pkg::TICKET_W-1:0] ticket_out;
	logic [tfl_pkg::HANDLE_W-1:0] handle_out;
	logic                         status;

	int                           check_errors;
	int                           due_count;
	logic [tfl_pkg::TICKET_W-1:0] held_tickets [$];
	logic [tfl_pkg::OPCODE_W-1:0] sent_ops [$];
	bit                           track_held = 1'b0;
	bit                           send_burst = 1'b0;
	bit                           take_burst = 1'b0;

	ticket_free_list_allocator u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.ticket_in  (ticket_in),
		.handle_in  (handle_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ticket_out (ticket_out),
		.handle_out (handle_out),
		.status     (status)
	);

	tfl_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.ticket_in  (ticket_in),
		.handle_in  (handle_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ticket_out (ticket_out),
		.handle_out (handle_out),
		.status     (status),
		.errors     (check_errors),
		.pending    (due_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("tb_ticket_free_list_allocator: done, errors");
		$finish;
	end

	// granted tickets steer well-formed releases and lookups
	always @(posedge clk) begin
		logic [tfl_pkg::OPCODE_W-1:0] op;
		if (out_valid && out_ready && sent_ops.size() != 0) begin
			op = sent_ops.pop_front();
			if (track_held && op == tfl_pkg::OP_ALLOC && status == 1'b0)
				held_tickets.push_back(ticket_out);
		end
		if (in_valid && in_ready)
			sent_ops.push_back(opcode);
	end

	task automatic send_word(logic [tfl_pkg::OPCODE_W-1:0] op,
			logic [tfl_pkg::TICKET_W-1:0] tk, logic [tfl_pkg::HANDLE_W-1:0] hd);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		ticket_in <= tk;
		handle_in <= hd;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin : take_side
		int wait_cycles;
		int left;
		left = 0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (left == 0) begin
				take_burst = ($urandom_range(0, 3) == 0);
				left       = $urandom_range(20, 80);
			end
			left--;
			wait_cycles = take_burst ? 0 : $urandom_range(0, 19);
			if (wait_cycles != 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	initial begin : make_side
		round_kind_t                  kind;
		int                           sent;
		int                           round_no;
		int                           len;
		int                           roll;
		int                           idx;
		logic [tfl_pkg::OPCODE_W-1:0] op;
		logic [tfl_pkg::TICKET_W-1:0] tk;
		logic [tfl_pkg::HANDLE_W-1:0] hd;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, every opcode, slot reuse after release
		send_word(tfl_pkg::OP_LOOKUP,  8'h00, 32'h0000_0000);
		send_word(tfl_pkg::OP_ALLOC,   8'hFF, 32'hFFFF_FFFF);
		send_word(tfl_pkg::OP_ALLOC,   8'h00, 32'h0000_0000);
		send_word(tfl_pkg::OP_ALLOC,   8'h5A, 32'hA5A5_5A5A);
		send_word(tfl_pkg::OP_LOOKUP,  8'h00, 32'h0000_0000);
		send_word(tfl_pkg::OP_LOOKUP,  8'h02, 32'hFFFF_FFFF);
		send_word(tfl_pkg::OP_LOOKUP,  8'hFF, 32'h0000_0000);
		send_word(tfl_pkg::OP_RELEASE, 8'h01, 32'hFFFF_FFFF);
		send_word(tfl_pkg::OP_LOOKUP,  8'h01, 32'h0000_0000);
		send_word(tfl_pkg::OP_ALLOC,   8'hC3, 32'h1234_5678);
		send_word(tfl_pkg::OP_LOOKUP,  8'h01, 32'h0000_0000);
		send_word(OP_UNUSED,           8'hFF, 32'hFFFF_FFFF);
		send_word(OP_UNUSED,           8'h00, 32'h0000_0000);
		send_word(tfl_pkg::OP_LOOKUP,  8'h00, 32'h0000_0000);
		send_word(tfl_pkg::OP_RELEASE, 8'h00, 32'h0000_0000);
		send_word(tfl_pkg::OP_RELEASE, 8'h02, 32'h5555_AAAA);
		send_word(tfl_pkg::OP_RELEASE, 8'h01, 32'h0000_0000);
		send_word(tfl_pkg::OP_LOOKUP,  8'h02, 32'h0000_0000);
		in_valid <= 1'b0;
		while (due_count != 0) @(negedge clk);
		held_tickets.delete();
		track_held = 1'b1;

		// random rounds: fill to full first, then drain, mix and some noise
		sent     = 0;
		round_no = 0;
		while (sent < RANDOM_WORDS) begin
			if (round_no == 0)
				kind = RND_FILL;
			else if (round_no == 1)
				kind = RND_DRAIN;
			else begin
				roll = $urandom_range(0, 9);
				kind = (roll < 4) ? RND_MIX : (roll < 6) ? RND_FILL :
					(roll < 8) ? RND_DRAIN : RND_NOISE;
			end
			len        = (round_no == 0) ? 320 : $urandom_range(40, 160);
			send_burst = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < len; n++) begin
				roll = $urandom_range(0, 99);
				hd   = $urandom;
				tk   = tfl_pkg::TICKET_W'($urandom_range(0, 255));
				case (kind)
					RND_NOISE: op = tfl_pkg::OPCODE_W'($urandom_range(0, 3));
					RND_FILL:  op = (roll < 90) ? tfl_pkg::OP_ALLOC : tfl_pkg::OP_LOOKUP;
					RND_DRAIN: op = (roll < 70) ? tfl_pkg::OP_RELEASE : tfl_pkg::OP_LOOKUP;
					default:   op = (roll < 40) ? tfl_pkg::OP_ALLOC :
						(roll < 75) ? tfl_pkg::OP_RELEASE : tfl_pkg::OP_LOOKUP;
				endcase
				if (kind == RND_NOISE) begin
					if (op == tfl_pkg::OP_RELEASE) begin
						idx = -1;
						for (int k = 0; k < held_tickets.size(); k++)
							if (idx < 0 && held_tickets[k] == tk)
								idx = k;
						if (idx >= 0)
							held_tickets.delete(idx);
					end
				end else if (held_tickets.size() != 0 &&
						(op == tfl_pkg::OP_RELEASE || $urandom_range(0, 9) < 7)) begin
					idx = $urandom_range(0, held_tickets.size() - 1);
					tk  = held_tickets[idx];
					if (op == tfl_pkg::OP_RELEASE)
						held_tickets.delete(idx);
				end else if (op == tfl_pkg::OP_RELEASE) begin
					op = tfl_pkg::OP_LOOKUP;
				end
				send_word(op, tk, hd);
				sent++;
			end
			round_no++;
		end
		in_valid <= 1'b0;

		while (due_count != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (check_errors == 0 && due_count == 0)
			$display("tb_ticket_free_list_allocator: done, clean");
		else
			$display("tb_ticket_free_list_allocator: done, errors");
		$finish;
	end

endmodule
